// ===== sv/banked_register_file_top_assert.svh =====
// Assertion macros for the banked register file.
// Used by banked_register_file_top; no other dependencies.
`ifndef BANKED_REGISTER_FILE_TOP_ASSERT_SVH
`define BANKED_REGISTER_FILE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/brf_pkg.sv =====
// Shared types and constants of the banked register file.
// No dependencies; imported by the interfaces and all modules.
package brf_pkg;

  localparam int REG_W     = 32;
  localparam int IDX_W     = 4;
  localparam int MODE_W    = 3;
  localparam int OP_W      = 2;
  // Distinct physical registers: R0-R7, R15, two R8-R12 banks, six R13-R14 banks.
  localparam int PHYS_REGS = 31;
  localparam int ADDR_W    = $clog2(PHYS_REGS);

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SWITCH = 2'd2
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_USR = 3'd0,
    MODE_FIQ = 3'd1,
    MODE_IRQ = 3'd2,
    MODE_SVC = 3'd3,
    MODE_ABT = 3'd4,
    MODE_UND = 3'd5,
    MODE_SYS = 3'd6
  } mode_t;

  // Architectural register numbers with special meaning.
  localparam logic [IDX_W-1:0] IDX_FIRST_BANKED = 4'd8;
  localparam logic [IDX_W-1:0] IDX_SP           = 4'd13;
  localparam logic [IDX_W-1:0] IDX_PC           = 4'd15;

  // Physical addresses of the private banks. Addresses 0..15 hold the
  // unbanked registers and the user/system view of R8-R14.
  localparam logic [ADDR_W-1:0] PA_FIQ_HI = 5'd16;
  localparam logic [ADDR_W-1:0] PA_FIQ_SL = 5'd21;
  localparam logic [ADDR_W-1:0] PA_IRQ_SL = 5'd23;
  localparam logic [ADDR_W-1:0] PA_SVC_SL = 5'd25;
  localparam logic [ADDR_W-1:0] PA_ABT_SL = 5'd27;
  localparam logic [ADDR_W-1:0] PA_UND_SL = 5'd29;

  // Memory access request from the bank mapper.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
  } mem_req_t;

endpackage

// ===== sv/brf_if.sv =====
// Valid/ready channel interfaces for the banked register file.
// Depends on brf_pkg for field widths.
interface brf_in_if;
  import brf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  reg_index;
  logic [MODE_W-1:0] mode;
  logic [REG_W-1:0]  write_data;

  modport source (output valid, output operation, output reg_index, output mode,
                  output write_data, input ready);
  modport sink   (input valid, input operation, input reg_index, input mode,
                  input write_data, output ready);
endinterface

interface brf_out_if;
  import brf_pkg::*;

  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  read_data;
  logic [MODE_W-1:0] current_mode_out;
  logic              is_usr;

  modport source (output valid, output read_data, output current_mode_out,
                  output is_usr, input ready);
  modport sink   (input valid, input read_data, input current_mode_out,
                  input is_usr, output ready);
endinterface

// ===== sv/brf_bank_map.sv =====
// Maps an architectural register and viewing mode to a physical address.
// Depends on brf_pkg.
module brf_bank_map (
  input  logic                          accept,
  input  logic [brf_pkg::OP_W-1:0]      operation,
  input  logic [brf_pkg::IDX_W-1:0]     reg_index,
  input  logic [brf_pkg::MODE_W-1:0]    mode,
  input  logic [brf_pkg::MODE_W-1:0]    cur_mode,
  output brf_pkg::mem_req_t             req
);
  import brf_pkg::*;

  logic [MODE_W-1:0] eff_mode;
  logic [ADDR_W-1:0] sl_base;
  logic              sl_banked;
  logic              sl_off;

  // An undefined viewing mode stands for the current mode.
  assign eff_mode = (mode > MODE_SYS) ? cur_mode : mode;

  // R13 selects offset 0, R14 offset 1.
  assign sl_off = reg_index[1];

  // Private stack/link bank of the viewing mode; user and system share addresses 13-14.
  always_comb begin
    sl_base   = PA_FIQ_SL;
    sl_banked = 1'b1;
    unique case (mode_t'(eff_mode))
      MODE_FIQ: sl_base = PA_FIQ_SL;
      MODE_IRQ: sl_base = PA_IRQ_SL;
      MODE_SVC: sl_base = PA_SVC_SL;
      MODE_ABT: sl_base = PA_ABT_SL;
      MODE_UND: sl_base = PA_UND_SL;
      default:  sl_banked = 1'b0;
    endcase
  end

  // Address selection by register group, and the access strobes.
  always_comb begin
    req.rd   = accept && (operation == OP_READ);
    req.wr   = accept && (operation == OP_WRITE);
    req.addr = ADDR_W'(reg_index);
    if (reg_index >= IDX_FIRST_BANKED && reg_index < IDX_SP) begin
      if (eff_mode == MODE_FIQ) begin
        req.addr = PA_FIQ_HI + ADDR_W'(reg_index[2:0]);
      end
    end else if (reg_index >= IDX_SP && reg_index != IDX_PC) begin
      if (sl_banked) begin
        req.addr = sl_base + ADDR_W'(sl_off);
      end
    end
  end

endmodule

// ===== sv/brf_regmem.sv =====
// Physical register memory with a registered read port.
// Depends on brf_pkg; valid bits make unwritten entries read as zero.
module brf_regmem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brf_pkg::mem_req_t          req,
  input  logic [brf_pkg::REG_W-1:0]  wr_data,
  output logic [brf_pkg::REG_W-1:0]  rd_data
);
  import brf_pkg::*;

  logic [REG_W-1:0]     mem [PHYS_REGS];
  logic [PHYS_REGS-1:0] valid_r;
  logic [REG_W-1:0]     rd_q_r;
  logic                 rd_vld_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= wr_data;
    end
  end

  // Per-entry valid bits stand in for the all-zero reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_q_r   <= mem[req.addr];
      rd_vld_r <= valid_r[req.addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== sv/banked_register_file_top.sv =====
// Channel     | Dir | Beat payload
// ------------+-----+------------------------------------------------
// in_ch       | in  | operation, reg_index, mode, write_data
// out_ch      | out | read_data, current_mode_out, is_usr
//
// One item per cycle while out_ch is ready; each result appears in the cycle
// after its beat is accepted, set by the registered read port of the register memory.
// Reset is synchronous and active low: system mode, all registers zero via
// per-entry valid bits, so no clearing pass is needed.
// A stalled result holds the output stage; a new beat is taken in the same
// cycle the waiting result is taken.
// Depends on brf_pkg, brf_if, brf_bank_map, brf_regmem and the assertion header.
module banked_register_file_top (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch
);
  import brf_pkg::*;

  logic              acc;
  logic [MODE_W-1:0] cur_mode_r;
  logic [MODE_W-1:0] cur_mode_nxt;
  logic              out_valid_r;
  logic              out_read_r;
  logic [MODE_W-1:0] out_mode_r;
  logic              out_user_r;
  logic [REG_W-1:0]  mem_rd_data;
  mem_req_t          req;

  // Accept when the output stage is empty or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  brf_bank_map u_map (
    .accept    (acc),
    .operation (in_ch.operation),
    .reg_index (in_ch.reg_index),
    .mode      (in_ch.mode),
    .cur_mode  (cur_mode_r),
    .req       (req)
  );

  brf_regmem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (in_ch.write_data),
    .rd_data (mem_rd_data)
  );

  // A mode switch retargets the bank map and the reported mode; an undefined mode is ignored.
  always_comb begin
    cur_mode_nxt = cur_mode_r;
    if (acc && in_ch.operation == OP_SWITCH && in_ch.mode <= MODE_SYS) begin
      cur_mode_nxt = in_ch.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mode_r <= MODE_SYS;
    end else begin
      cur_mode_r <= cur_mode_nxt;
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_read_r <= (in_ch.operation == OP_READ);
      out_mode_r <= cur_mode_nxt;
      out_user_r <= (cur_mode_nxt == MODE_USR);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_data        = out_read_r ? mem_rd_data : '0;
  assign out_ch.current_mode_out = out_mode_r;
  assign out_ch.is_usr           = out_user_r;

`include "banked_register_file_top_assert.svh"

  `BRF_ASSERT_IMPL(a_addr_legal, clk, rst_n, (req.rd || req.wr), (req.addr < ADDR_W'(PHYS_REGS)), "register access maps outside the physical register memory")
  `BRF_ASSERT_NEXT(a_switch_mode, clk, rst_n, (acc && in_ch.operation == OP_SWITCH && in_ch.mode <= MODE_SYS), (cur_mode_r == $past(in_ch.mode)), "mode switch did not take effect")
  `BRF_ASSERT_NEXT(a_result_follows, clk, rst_n, acc, out_valid_r, "accepted beat produced no result")
  `BRF_ASSERT_IMPL(a_mode_coherent, clk, rst_n, out_valid_r, (out_mode_r == cur_mode_r), "pending result disagrees with current mode")

endmodule
